// File: rtl/shc_pkg.sv
package shc_pkg;

    localparam int COEFF_SLOTS = 16;
    localparam int IDX_W       = 4;
    localparam int COEFF_W     = 32;
    localparam int DIR_W       = 16;
    localparam int MUL_W       = 35;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 68;
    localparam int ROOT_W      = 32;
    localparam int NUM_W       = 48;
    localparam int QUO_W       = 18;
    localparam int S_DATA_W    = 88;
    localparam int TERMS       = 16;

    // Basis constants in Q4.28, sign folded in, one per coefficient slot.
    function automatic logic signed [31:0] basis_const(input logic [3:0] k);
        logic signed [31:0] c;
        begin
            unique case (k)
                4'd0:    c = 32'sd75724244;
                4'd1:    c = -32'sd131158238;
                4'd2:    c = 32'sd131158238;
                4'd3:    c = -32'sd131158238;
                4'd4:    c = 32'sd293278736;
                4'd5:    c = -32'sd293278736;
                4'd6:    c = 32'sd84662279;
                4'd7:    c = -32'sd293278736;
                4'd8:    c = 32'sd146639368;
                4'd9:    c = -32'sd158388620;
                4'd10:   c = 32'sd775942601;
                4'd11:   c = -32'sd122687298;
                4'd12:   c = 32'sd100173759;
                4'd13:   c = -32'sd122687298;
                4'd14:   c = 32'sd387971300;
                default: c = -32'sd158388620;
            endcase
            return c;
        end
    endfunction

    // A term contributes only when its order is within the configured degree.
    function automatic logic term_enabled(input logic [3:0] k, input logic [1:0] deg);
        logic en;
        begin
            if (k == 4'd0)
                en = 1'b1;
            else if (k <= 4'd3)
                en = (deg >= 2'd1);
            else if (k <= 4'd8)
                en = (deg >= 2'd2);
            else
                en = (deg == 2'd3);
            return en;
        end
    endfunction

    // Divide by 2^s, rounding half away from zero.
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              s
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        begin
            mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
            r   = (mag + (PROD_W'(1) << (s - 1))) >> s;
            return v[PROD_W-1] ? $signed(-r) : $signed(r);
        end
    endfunction

endpackage

// File: rtl/shc_sqrt.sv
module shc_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  s,
    output logic                         done,
    output logic [shc_pkg::ROOT_W-1:0]   root
);
    import shc_pkg::*;

    // Digit-by-digit root of s * 2^32, one result bit per cycle.
    logic [63:0]        rad_reg;
    logic [33:0]        rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [35:0]        rem_sh;
    logic [35:0]        trial;

    assign rem_sh = {rem_reg, rad_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= {s, 32'd0};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'd31;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= 34'(rem_sh - trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[33:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/shc_div.sv
module shc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [shc_pkg::NUM_W-1:0]   num,
    input  logic [shc_pkg::ROOT_W-1:0]  den,
    output logic                        done,
    output logic [shc_pkg::QUO_W-1:0]   quo
);
    import shc_pkg::*;

    // Restoring division, one quotient bit per cycle. The upper numerator
    // bits are known to be below the divisor, so only QUO_W steps are run.
    logic [ROOT_W-1:0]  den_reg;
    logic [ROOT_W-1:0]  rem_reg;
    logic [QUO_W-1:0]   nsh_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [ROOT_W:0]    rem_sh;

    assign rem_sh = {rem_reg, nsh_reg[QUO_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg  <= den;
                rem_reg  <= ROOT_W'(num[NUM_W-1:QUO_W]);
                nsh_reg  <= num[QUO_W-1:0];
                cnt_reg  <= 5'(QUO_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                nsh_reg <= {nsh_reg[QUO_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= ROOT_W'(rem_sh - {1'b0, den_reg});
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[ROOT_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/sh_color_eval.sv
// A load word is stored in the idle state, so the block stays ready for the next word.
// An evaluate word runs a 32-step bit-serial root, three divisions and the products
// through the single shared 35x35 multiplier; degree 0 skips the root and the
// divisions, as does a zero direction.
// One word is worked at a time; a result that cannot leave holds the block busy.
// rst_n clears the degree register, the coefficient store and all control.
module sh_color_eval (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // coeff_index[3:0], coeff_value[35:4], dir_x[51:36], dir_y[67:52],
    // dir_z[83:68], zero fill[87:84]
    input  logic [shc_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode[0]: 0 loads a coefficient, 1 evaluates
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // color[31:0]
    output logic [31:0]                    m_tdata,
    // saturated[0]
    output logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_wdata
);
    import shc_pkg::*;

    localparam logic OP_LOAD = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOTGO,
        S_ROOTW,
        S_DIVGO,
        S_DIVW,
        S_PROD,
        S_EVAL
    } state_t;

    state_t                     state_reg;
    logic [1:0]                 deg_reg;
    logic [COEFF_W-1:0]         coeff_reg [COEFF_SLOTS];

    // Raw direction and its normalized Q1.15 components.
    logic signed [DIR_W-1:0]    rx_reg, ry_reg, rz_reg;
    logic signed [DIR_W-1:0]    x_reg, y_reg, z_reg;
    // Exact Q30 products of the components.
    logic signed [31:0]         xx_reg, yy_reg, zz_reg, xy_reg, yz_reg, xz_reg;

    logic [31:0]                ssum_reg;
    logic [2:0]                 cnt_reg;
    logic [1:0]                 ci_reg;
    logic [3:0]                 k_reg;
    logic [2:0]                 ph_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [MUL_W-1:0]    pr_reg;
    logic signed [MUL_W-1:0]    q_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic                       m_tvalid_reg;
    logic [31:0]                color_reg;
    logic                       sat_reg;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [MUL_W-1:0]    xe, ye, ze, xxe, yye, zze, xye, yze, xze;
    logic signed [MUL_W-1:0]    poly_lo;
    logic signed [PROD_W-1:0]   pr_round;
    logic signed [PROD_W-1:0]   q_round;

    logic                       sqrt_start;
    logic                       sqrt_done;
    logic [ROOT_W-1:0]          root;
    logic                       div_start;
    logic                       div_done;
    logic [QUO_W-1:0]           quo;
    logic signed [DIR_W-1:0]    cur_dir;
    logic signed [DIR_W:0]      cur_ext;
    logic [DIR_W:0]             cur_mag;
    logic [NUM_W-1:0]           div_num;
    logic [DIR_W-2:0]           q_cap;
    logic signed [DIR_W-1:0]    comp_val;

    logic signed [PROD_W-1:0]   color_full;
    logic                       color_ovf;
    logic signed [ACC_W-1:0]    acc_add;
    logic signed [ACC_W-1:0]    acc_ofs;

    logic                       accept;
    logic                       res_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = color_reg;
    assign m_tuser  = sat_reg;

    // The finished color moves into the output register once it is free.
    assign res_load = (state_reg == S_EVAL) && (ph_reg == 3'd6) &&
                      (!m_tvalid_reg || m_tready);

    // Sign-extended views used by the polynomial terms.
    assign xe  = MUL_W'(x_reg);
    assign ye  = MUL_W'(y_reg);
    assign ze  = MUL_W'(z_reg);
    assign xxe = MUL_W'(xx_reg);
    assign yye = MUL_W'(yy_reg);
    assign zze = MUL_W'(zz_reg);
    assign xye = MUL_W'(xy_reg);
    assign yze = MUL_W'(yz_reg);
    assign xze = MUL_W'(xz_reg);

    // Rounded forms of the multiplier output for the cubic and basis steps.
    assign pr_round = round_shift(prod_reg, 15);
    assign q_round  = round_shift(prod_reg, 34);

    // Q30 polynomial for orders 0 to 2, formed from the stored products.
    always_comb
    begin
        unique case (k_reg)
            4'd0:    poly_lo = MUL_W'(36'sh040000000);
            4'd1:    poly_lo = ye <<< 15;
            4'd2:    poly_lo = ze <<< 15;
            4'd3:    poly_lo = xe <<< 15;
            4'd4:    poly_lo = xye;
            4'd5:    poly_lo = yze;
            4'd6:    poly_lo = 2 * zze - xxe - yye;
            4'd7:    poly_lo = xze;
            default: poly_lo = xxe - yye;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ:
            begin
                unique case (cnt_reg)
                    3'd0:    begin mul_a = MUL_W'(rx_reg); mul_b = MUL_W'(rx_reg); end
                    3'd1:    begin mul_a = MUL_W'(ry_reg); mul_b = MUL_W'(ry_reg); end
                    3'd2:    begin mul_a = MUL_W'(rz_reg); mul_b = MUL_W'(rz_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_PROD:
            begin
                unique case (cnt_reg)
                    3'd0:    begin mul_a = xe; mul_b = xe; end
                    3'd1:    begin mul_a = ye; mul_b = ye; end
                    3'd2:    begin mul_a = ze; mul_b = ze; end
                    3'd3:    begin mul_a = xe; mul_b = ye; end
                    3'd4:    begin mul_a = ye; mul_b = ze; end
                    3'd5:    begin mul_a = xe; mul_b = ze; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_EVAL:
            begin
                unique case (ph_reg)
                    3'd0:
                    begin
                        // Cubic terms: component times a quadratic factor.
                        unique case (k_reg)
                            4'd9:    begin mul_a = ye; mul_b = 3 * xxe - yye; end
                            4'd10:   begin mul_a = xye; mul_b = ze; end
                            4'd11:   begin mul_a = ye; mul_b = 4 * zze - xxe - yye; end
                            4'd12:   begin mul_a = ze; mul_b = 2 * zze - 3 * xxe - 3 * yye; end
                            4'd13:   begin mul_a = xe; mul_b = 4 * zze - xxe - yye; end
                            4'd14:   begin mul_a = ze; mul_b = xxe - yye; end
                            4'd15:   begin mul_a = xe; mul_b = xxe - 3 * yye; end
                            default: begin mul_a = '0; mul_b = '0; end
                        endcase
                    end
                    3'd2:    begin mul_a = MUL_W'(basis_const(k_reg)); mul_b = pr_reg; end
                    3'd4:    begin mul_a = q_reg; mul_b = MUL_W'($signed(coeff_reg[k_reg])); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Division operands for the component being normalized.
    always_comb
    begin
        unique case (ci_reg)
            2'd0:    cur_dir = rx_reg;
            2'd1:    cur_dir = ry_reg;
            default: cur_dir = rz_reg;
        endcase
        cur_ext = (DIR_W + 1)'(cur_dir);
        cur_mag = cur_ext[DIR_W] ? (DIR_W + 1)'(-cur_ext) : (DIR_W + 1)'(cur_ext);
        div_num = NUM_W'({cur_mag[DIR_W-1:0], 31'd0}) + NUM_W'(root >> 1);
        q_cap   = (quo > QUO_W'(32767)) ? 15'h7fff : quo[DIR_W-2:0];
        comp_val = cur_ext[DIR_W] ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
    end

    assign sqrt_start = (state_reg == S_ROOTGO);
    assign div_start  = (state_reg == S_DIVGO);

    // Term accumulation and the final rounding to Q16 with saturation.
    assign acc_add = term_enabled(k_reg, deg_reg) ? ACC_W'(prod_reg) : '0;
    assign acc_ofs = ((k_reg == 4'(TERMS - 1)) && (deg_reg == 2'd3))
                     ? (ACC_W'(1) <<< 39) : '0;
    assign color_full = round_shift(PROD_W'(acc_reg), 24);
    assign color_ovf  = (color_full[PROD_W-1:31] != '0) && (color_full[PROD_W-1:31] != '1);

    shc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .s     (ssum_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    shc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (root),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            deg_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            ci_reg       <= '0;
            k_reg        <= '0;
            ph_reg       <= '0;
            for (int i = 0; i < COEFF_SLOTS; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (cfg_we)
            begin
                deg_reg <= cfg_wdata;
            end
            if (res_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser == OP_LOAD)
                        begin
                            if ({1'b0, s_tdata[3:0]} < 5'(COEFF_SLOTS))
                            begin
                                coeff_reg[s_tdata[3:0]] <= s_tdata[35:4];
                            end
                        end
                        else
                        begin
                            rx_reg  <= s_tdata[51:36];
                            ry_reg  <= s_tdata[67:52];
                            rz_reg  <= s_tdata[83:68];
                            x_reg   <= '0;
                            y_reg   <= '0;
                            z_reg   <= '0;
                            acc_reg <= '0;
                            cnt_reg <= '0;
                            ci_reg  <= '0;
                            k_reg   <= '0;
                            ph_reg  <= '0;
                            // At degree zero the direction plays no part.
                            state_reg <= (deg_reg == 2'd0) ? S_PROD : S_SQ;
                        end
                    end
                end
                S_SQ:
                begin
                    unique case (cnt_reg)
                        3'd0:    ssum_reg <= ssum_reg;
                        3'd1:    ssum_reg <= prod_reg[31:0];
                        default: ssum_reg <= ssum_reg + prod_reg[31:0];
                    endcase
                    if (cnt_reg == 3'd3)
                    begin
                        cnt_reg <= '0;
                        // A zero vector keeps its components at zero.
                        if ((ssum_reg + prod_reg[31:0]) == 32'd0)
                        begin
                            state_reg <= S_PROD;
                        end
                        else
                        begin
                            state_reg <= S_ROOTGO;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_ROOTGO:
                begin
                    state_reg <= S_ROOTW;
                end
                S_ROOTW:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= S_DIVGO;
                    end
                end
                S_DIVGO:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        unique case (ci_reg)
                            2'd0:    x_reg <= comp_val;
                            2'd1:    y_reg <= comp_val;
                            default: z_reg <= comp_val;
                        endcase
                        if (ci_reg == 2'd2)
                        begin
                            state_reg <= S_PROD;
                        end
                        else
                        begin
                            ci_reg    <= ci_reg + 2'd1;
                            state_reg <= S_DIVGO;
                        end
                    end
                end
                S_PROD:
                begin
                    unique case (cnt_reg)
                        3'd0:    xx_reg <= xx_reg;
                        3'd1:    xx_reg <= prod_reg[31:0];
                        3'd2:    yy_reg <= prod_reg[31:0];
                        3'd3:    zz_reg <= prod_reg[31:0];
                        3'd4:    xy_reg <= prod_reg[31:0];
                        3'd5:    yz_reg <= prod_reg[31:0];
                        default: xz_reg <= prod_reg[31:0];
                    endcase
                    if (cnt_reg == 3'd6)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_EVAL:
                begin
                    unique case (ph_reg)
                        3'd1:
                        begin
                            ph_reg <= ph_reg + 3'd1;
                            if (k_reg >= 4'd9)
                            begin
                                pr_reg <= pr_round[MUL_W-1:0];
                            end
                            else
                            begin
                                pr_reg <= poly_lo;
                            end
                        end
                        3'd3:
                        begin
                            ph_reg <= ph_reg + 3'd1;
                            q_reg  <= q_round[MUL_W-1:0];
                        end
                        3'd5:
                        begin
                            acc_reg <= acc_reg + acc_add + acc_ofs;
                            if (k_reg == 4'(TERMS - 1))
                            begin
                                ph_reg <= 3'd6;
                            end
                            else
                            begin
                                ph_reg <= '0;
                                k_reg  <= k_reg + 4'd1;
                            end
                        end
                        3'd6:
                        begin
                            // Hold here until the output register is free.
                            if (res_load)
                            begin
                                color_reg    <= color_ovf
                                    ? (color_full[PROD_W-1] ? 32'h8000_0000 : 32'h7fff_ffff)
                                    : color_full[31:0];
                                sat_reg      <= color_ovf;
                                ph_reg       <= '0;
                                k_reg        <= '0;
                                state_reg    <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            ph_reg <= ph_reg + 3'd1;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_LOAD)) |=> (state_reg == S_IDLE))
        else $error("load word left the idle state");

    a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_EVAL))
        else $error("result raised outside of the evaluation");

    a_sat_is_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && sat_reg) |-> ((color_reg == 32'h7fff_ffff) ||
                                       (color_reg == 32'h8000_0000)))
        else $error("saturation flag without a clipped color");

    a_comp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> ((x_reg != 16'sh8000) && (y_reg != 16'sh8000) &&
                                   (z_reg != 16'sh8000)))
        else $error("normalized component out of Q1.15 range");
`endif

endmodule

// File: bench/sh_color_eval_checker.sv
`timescale 1ns / 1ps

module sh_color_eval_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [shc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [31:0]                  m_tdata,
    input  logic                         m_tuser,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_wdata,
    output int                           errors,
    output int                           pending
);
    import shc_pkg::*;

    localparam logic OP_LOAD = 1'b0;

    localparam longint K0  = 75724244;
    localparam longint K1  = 131158238;
    localparam longint K2A = 293278736;
    localparam longint K2C = 84662279;
    localparam longint K2E = 146639368;
    localparam longint K3A = 158388620;
    localparam longint K3B = 775942601;
    localparam longint K3C = 122687298;
    localparam longint K3D = 100173759;
    localparam longint K3F = 387971300;

    typedef struct packed {
        logic [31:0] color;
        logic        sat;
    } color_t;

    logic signed [31:0] coeffs [COEFF_SLOTS];
    logic [1:0]         degree;
    color_t             expected_colors [$];

    assign pending = expected_colors.size();

    // Divide by 2^s with rounding half away from zero.
    function automatic longint round_half(input longint v, input int s);
        longint mag;
        longint r;
        begin
            mag = (v < 0) ? -v : v;
            r   = (mag + (longint'(1) <<< (s - 1))) >>> s;
            return (v < 0) ? -r : r;
        end
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        begin
            res = 0;
            b   = 64'h4000_0000_0000_0000;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        end
    endfunction

    // Component scaled to Q1.15; a full-scale 1.0 is clipped to 32767.
    function automatic longint unit_comp(input longint v, input longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        begin
            mag = (v < 0) ? longint'(-v) : longint'(v);
            q   = ((mag << 31) + (r >> 1)) / r;
            if (q > 32767)
                q = 32767;
            return (v < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint weighted(input longint c28, input longint p30, input int k);
        begin
            return round_half(c28 * p30, 34) * longint'(coeffs[k]);
        end
    endfunction

    function automatic color_t predict_color(input logic signed [15:0] dx,
                                             input logic signed [15:0] dy,
                                             input logic signed [15:0] dz);
        longint          x, y, z, xx, yy, zz, xy, yz, xz, acc, c;
        longint unsigned s, r;
        color_t          res;
        begin
            x = 0; y = 0; z = 0;
            acc = weighted(K0, longint'(1) <<< 30, 0);
            if (degree >= 1)
            begin
                s = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
                if (s != 0)
                begin
                    r = int_sqrt(s << 32);
                    x = unit_comp(dx, r);
                    y = unit_comp(dy, r);
                    z = unit_comp(dz, r);
                end
                acc += weighted(-K1, y * 32768, 1);
                acc += weighted(K1, z * 32768, 2);
                acc += weighted(-K1, x * 32768, 3);
            end
            xx = x * x; yy = y * y; zz = z * z;
            xy = x * y; yz = y * z; xz = x * z;
            if (degree >= 2)
            begin
                acc += weighted(K2A, xy, 4);
                acc += weighted(-K2A, yz, 5);
                acc += weighted(K2C, 2 * zz - xx - yy, 6);
                acc += weighted(-K2A, xz, 7);
                acc += weighted(K2E, xx - yy, 8);
            end
            if (degree == 3)
            begin
                acc += weighted(-K3A, round_half(y * (3 * xx - yy), 15), 9);
                acc += weighted(K3B, round_half(xy * z, 15), 10);
                acc += weighted(-K3C, round_half(y * (4 * zz - xx - yy), 15), 11);
                acc += weighted(K3D, round_half(z * (2 * zz - 3 * xx - 3 * yy), 15), 12);
                acc += weighted(-K3C, round_half(x * (4 * zz - xx - yy), 15), 13);
                acc += weighted(K3F, round_half(z * (xx - yy), 15), 14);
                acc += weighted(-K3A, round_half(x * (xx - 3 * yy), 15), 15);
                acc += longint'(1) <<< 39;
            end
            c       = round_half(acc, 24);
            res.sat = 1'b0;
            if (c > 64'sd2147483647)
            begin
                c       = 64'sd2147483647;
                res.sat = 1'b1;
            end
            if (c < -64'sd2147483648)
            begin
                c       = -64'sd2147483648;
                res.sat = 1'b1;
            end
            res.color = c[31:0];
            return res;
        end
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < COEFF_SLOTS; i++)
                coeffs[i] <= '0;
            degree <= '0;
            errors = 0;
            expected_colors.delete();
        end
        else
        begin
            if (cfg_we)
                degree <= cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_LOAD)
                    coeffs[s_tdata[3:0]] <= s_tdata[35:4];
                else
                    expected_colors.push_back(predict_color(s_tdata[51:36],
                                                            s_tdata[67:52],
                                                            s_tdata[83:68]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_colors.size() == 0)
                    report("unexpected word", m_tdata, 32'h0);
                else
                begin
                    want = expected_colors.pop_front();
                    if (m_tdata !== want.color)
                        report("color", m_tdata, want.color);
                    if (m_tuser !== want.sat)
                        report("saturated", {31'b0, m_tuser}, {31'b0, want.sat});
                end
            end
        end
    end

endmodule

// File: bench/tb_sh_color_eval.sv
`timescale 1ns / 1ps

module tb_sh_color_eval;
    import shc_pkg::*;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // coeff_index[3:0], coeff_value[35:4], dir_x[51:36], dir_y[67:52], dir_z[83:68]
    logic [S_DATA_W-1:0]   s_tdata = '0;
    // opcode[0]
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // color[31:0]
    logic [31:0]           m_tdata;
    // saturated[0]
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_wdata = '0;
    int                    errors;
    int                    pending;
    // While set, neither the sender nor the receiver inserts idle cycles.
    logic                  no_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sh_color_eval i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    sh_color_eval_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .errors   (errors),
        .pending  (pending)
    );

    // The receiver stalls at random with a chance of 28 in 100 unless the
    // no-idle stretch is running.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(99) >= 28);
    end

    // Drive one word and hold it until the block takes it. The task returns
    // in the time step of the accepting edge, with tvalid still high.
    task automatic send_word(input logic op, input logic [3:0] idx,
                             input logic [31:0] value, input logic [15:0] dx,
                             input logic [15:0] dy, input logic [15:0] dz);
        begin
            if (!no_idle && $urandom_range(99) < 28)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < 28);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= {4'b0, dz, dy, dx, value, idx};
            do
                @(posedge clk);
            while (!s_tready);
        end
    endtask

    // The degree register may only change while nothing is in flight.
    // Loads are taken and stored in the idle state, so a short pause after the
    // last result is enough to cover a trailing load.
    task automatic set_degree(input logic [1:0] deg);
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= deg;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // Coefficients: mostly small values so sums stay in range, with some
    // full-range and extreme values so saturation shows up in both directions.
    function automatic logic [31:0] pick_coeff();
        int sel;
        begin
            sel = $urandom_range(7);
            if (sel < 2)
                return $urandom;
            else if (sel == 2)
                return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            else
                return 32'($signed($urandom_range(2097152)) - 1048576);
        end
    endfunction

    // Directions: full range, short vectors, zero, and single axis at full scale.
    task automatic pick_dir(output logic [15:0] dx, output logic [15:0] dy,
                            output logic [15:0] dz);
        int sel;
        begin
            sel = $urandom_range(9);
            dx = 16'($urandom); dy = 16'($urandom); dz = 16'($urandom);
            if (sel < 3)
            begin
                dx = 16'($signed($urandom_range(128)) - 64);
                dy = 16'($signed($urandom_range(128)) - 64);
                dz = 16'($signed($urandom_range(128)) - 64);
            end
            else if (sel == 3)
            begin
                dx = '0; dy = '0; dz = '0;
            end
            else if (sel == 4)
            begin
                dx = '0; dy = '0; dz = '0;
                case ($urandom_range(2))
                    0: dx = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                    1: dy = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                    default: dz = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                endcase
            end
        end
    endtask

    initial
    begin
        logic [1:0]  phase_degree [8] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3};
        logic [15:0] dx, dy, dz;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Degree zero after reset: only the constant term, direction unused.
        send_word(OP_LOAD, 4'd0, 32'h7fff_ffff, 16'h0, 16'h0, 16'h0);
        send_word(OP_EVAL, 4'd0, 32'h0, 16'h7fff, 16'h8000, 16'h1234);
        send_word(OP_LOAD, 4'd0, 32'h8000_0000, 16'h0, 16'h0, 16'h0);
        send_word(OP_EVAL, 4'd0, 32'h0, 16'h0, 16'h0, 16'h0);

        // Full degree with every slot loaded, then the corner directions:
        // zero vector, full-scale single axes that clip at 1.0, the diagonal.
        set_degree(2'd3);
        for (int k = 1; k < COEFF_SLOTS; k++)
            send_word(OP_LOAD, 4'(k), (k % 2) ? 32'h0001_0000 : 32'hffff_0000,
                      16'h0, 16'h0, 16'h0);
        send_word(OP_EVAL, 4'd0, 32'h0, 16'h0, 16'h0, 16'h0);
        send_word(OP_EVAL, 4'd0, 32'h0, 16'h8000, 16'h0, 16'h0);
        send_word(OP_EVAL, 4'd0, 32'h0, 16'h0, 16'h7fff, 16'h0);
        send_word(OP_EVAL, 4'd0, 32'h0, 16'h8000, 16'h8000, 16'h8000);

        // Random phases, each at its own degree; the fourth runs with no idling.
        for (int p = 0; p < 8; p++)
        begin
            set_degree(phase_degree[p]);
            no_idle <= (p == 3);
            for (int n = 0; n < 160; n++)
            begin
                pick_dir(dx, dy, dz);
                if ($urandom_range(9) < 4)
                    send_word(OP_LOAD, 4'($urandom_range(15)), pick_coeff(), dx, dy, dz);
                else
                    send_word(OP_EVAL, 4'($urandom_range(15)), $urandom, dx, dy, dz);
            end
        end
        s_tvalid <= 1'b0;
        no_idle  <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("[sh_color_eval] OK");
        else
            $display("[sh_color_eval] ERROR");
        $finish;
    end

    // Safety net well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("[sh_color_eval] ERROR");
        $finish;
    end

endmodule
